FILE: sv/shb_pkg.sv
`default_nettype none

package shb_pkg;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One input transaction and one result transaction.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    // Classified item as it travels through the queue.
    typedef enum logic {
        OP_DATA,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } entry_t;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Round functions: rotations are fixed rewirings.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/shb_front.sv
`default_nettype none

module shb_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire shb_pkg::item_t item,
    output logic                entry_valid,
    output shb_pkg::entry_t     entry,
    input  wire logic           entry_pop
);
    import shb_pkg::*;

    entry_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;
    entry_t              classified;

    // The queue is full when it holds QUEUE_DEPTH entries.
    assign item_stall  = (count_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign entry_valid = (count_reg != '0);
    assign entry       = queue_reg[rd_ptr_reg];
    assign push        = item_valid && !item_stall;
    assign pop         = entry_pop && entry_valid;

    // Classify the incoming transaction before it is queued.
    always_comb
    begin
        classified.op        = item.kind ? OP_FINISH : OP_DATA;
        classified.data_byte = item.kind ? 8'h00 : item.data_byte;
    end

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

FILE: sv/shb_core.sv
`default_nettype none

module shb_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            entry_valid,
    input  wire shb_pkg::entry_t entry,
    output logic                 entry_pop,
    output logic                 digest_valid,
    input  wire logic            digest_stall,
    output shb_pkg::digest_t     digest
);
    import shb_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [511:0]  block_reg;
    logic [5:0]    fill_reg;
    logic [63:0]   msg_reg;
    logic          mark_reg;
    logic          len_run_reg;
    logic          fin_reg;
    logic [5:0]    round_reg;
    logic [2:0]    word_reg;
    logic [31:0]   work_reg  [8];
    logic [31:0]   chain_reg [8];

    logic          push_en;
    logic [7:0]    push_byte;
    logic          count_en;
    logic          start_fin;
    logic          round_en;
    logic          add_en;
    logic          word_adv;
    logic          in_len;
    logic [63:0]   len_shift;
    logic [31:0]   w0;
    logic [31:0]   w1;
    logic [31:0]   w9;
    logic [31:0]   w14;
    logic [31:0]   w_new;
    logic [31:0]   t1;
    logic [31:0]   t2;
    logic [31:0]   ch;
    logic [31:0]   maj;

    // Length bytes follow the zero fill once offset 56 is reached.
    assign in_len    = !mark_reg && (len_run_reg || (fill_reg == LEN_OFFSET));
    assign len_shift = {msg_reg[60:0], 3'b000} << {fill_reg[2:0], 3'b000};

    // Message schedule taps on the block shift line.
    assign w0    = block_reg[511:480];
    assign w1    = block_reg[479:448];
    assign w9    = block_reg[223:192];
    assign w14   = block_reg[63:32];
    assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

    // One compression round.
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + ROUND_K[round_reg] + w0;
    assign t2  = big_sigma0(work_reg[0]) + maj;

    // Digest words are read straight from the chaining state.
    assign digest.digest_word = chain_reg[word_reg];
    assign digest.word_index  = word_reg;
    assign digest.last_word   = (word_reg == LAST_WORD);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (entry_valid)
                begin
                    if (entry.op == OP_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (fill_reg == LAST_SLOT)
                    begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LAST_SLOT)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (fin_reg && len_run_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!digest_stall && (word_reg == LAST_WORD))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        entry_pop    = 1'b0;
        push_en      = 1'b0;
        push_byte    = 8'h00;
        count_en     = 1'b0;
        start_fin    = 1'b0;
        round_en     = 1'b0;
        add_en       = 1'b0;
        digest_valid = 1'b0;
        word_adv     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                entry_pop = entry_valid;
                if (entry_valid && (entry.op == OP_DATA))
                begin
                    push_en   = 1'b1;
                    push_byte = entry.data_byte;
                    count_en  = 1'b1;
                end
                else if (entry_valid)
                begin
                    start_fin = 1'b1;
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (mark_reg)
                begin
                    push_byte = PAD_MARK;
                end
                else if (in_len)
                begin
                    push_byte = len_shift[63:56];
                end
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
            end
            ST_ADD:
            begin
                add_en = 1'b1;
            end
            ST_OUT:
            begin
                digest_valid = 1'b1;
                word_adv     = !digest_stall;
            end
            default:
            begin
                entry_pop = 1'b0;
            end
        endcase
    end

    // Control and chaining state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            msg_reg     <= '0;
            mark_reg    <= 1'b0;
            len_run_reg <= 1'b0;
            fin_reg     <= 1'b0;
            round_reg   <= '0;
            word_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (push_en)
            begin
                fill_reg <= fill_reg + 6'd1;
                mark_reg <= 1'b0;
                if (in_len && (state_reg == ST_PAD))
                begin
                    len_run_reg <= 1'b1;
                end
            end
            if (count_en)
            begin
                msg_reg <= msg_reg + 64'd1;
            end
            if (start_fin)
            begin
                fin_reg  <= 1'b1;
                mark_reg <= 1'b1;
            end
            if (round_en)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (add_en)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (word_adv)
            begin
                word_reg <= word_reg + 3'd1;
                if (word_reg == LAST_WORD)
                begin
                    fill_reg    <= '0;
                    msg_reg     <= '0;
                    fin_reg     <= 1'b0;
                    len_run_reg <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= INIT_HASH[i];
                    end
                end
            end
        end
    end

    // Block shift line and working variables.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            block_reg <= {block_reg[503:0], push_byte};
            if (fill_reg == LAST_SLOT)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    work_reg[i] <= chain_reg[i];
                end
            end
        end
        if (round_en)
        begin
            block_reg   <= {block_reg[479:0], w_new};
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sha256_byte_stream_hasher.sv
// Streaming SHA-256 hasher over a byte message.
// Input channel (item_valid, item_stall, item): each transaction carries either
// one message byte (kind 0) or a finish request (kind 1). A four-entry queue
// takes transactions while the hashing engine is busy; item_stall rises only
// when that queue is full.
// Output channel (digest_valid, digest_stall, digest): a finish request yields
// eight transactions, word 0 (most significant) first, the last one marked.
// Throughput: one data byte per cycle, except while the 64 rounds and the
// chaining add run after every 64th byte; the single round unit sets this limit.
// A finish leaves the queue, then the engine shifts in the padding bytes (9 to
// 72 bytes) and runs one or two compressions. The first digest word is valid
// once the last chaining add is done; the eight words then follow in order,
// each advancing when the receiver does not stall.
// While the receiver stalls, the current digest word holds and the engine waits;
// the queue keeps accepting until full.
// After the last digest word the block returns to its initial state for a new
// message. Reset clears the queue, the counters and loads the initial hash.
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire shb_pkg::item_t   item,
    output logic                  digest_valid,
    input  wire logic             digest_stall,
    output shb_pkg::digest_t      digest
);
    import shb_pkg::*;

    logic   entry_valid;
    entry_t entry;
    logic   entry_pop;

    // Front part: accepts and classifies transactions into the queue.
    shb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .entry_valid (entry_valid),
        .entry       (entry),
        .entry_pop   (entry_pop)
    );

    // Back part: block assembly, padding, compression and digest output.
    shb_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry        (entry),
        .entry_pop    (entry_pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

endmodule

`default_nettype wire
